@@ sv/gcr_pkg.sv @@
// ============================================================================
// Game controller readout package
// Shared types, codes and constants for the controller readout block.
// ============================================================================
package gcr_pkg;

    // Field and datapath widths
    localparam int POS_W   = 16;   // stick coordinate
    localparam int OP_W    = 17;   // coordinate after optional negation
    localparam int SENS_W  = 15;   // sensitivity / divisor
    localparam int CONST_W = 7;    // scale constants (114, 97, 62)
    localparam int NUM_W   = 22;   // |op| * constant, at most 32768 * 114
    localparam int CNT_W   = 5;    // divider step counter, holds NUM_W
    localparam int RES_W   = 24;   // signed centre + quotient before clamp

    // Input opcodes
    localparam logic OP_SET_POS    = 1'b0;
    localparam logic OP_SET_BUTTON = 1'b1;

    // Scale and clamp constants. Pen spans over twice the sensitivity are
    // folded to half the span over the sensitivity (same truncated quotient).
    localparam int PADDLE_CENTRE = 114;
    localparam int PADDLE_MIN    = 1;
    localparam int PADDLE_MAX    = 227;
    localparam int PEN_X_CENTRE  = 97;
    localparam int PEN_X_HALF    = 97;   // 194 / 2
    localparam int PEN_X_MIN     = 61;
    localparam int PEN_X_MAX     = 255;
    localparam int PEN_Y_CENTRE  = 62;
    localparam int PEN_Y_HALF    = 62;   // 124 / 2
    localparam int PEN_Y_MIN     = 0;
    localparam int PEN_Y_MAX     = 124;
    localparam logic [SENS_W-1:0] SENS_RESET = 15'd8192;
    localparam logic [SENS_W-1:0] SENS_MIN   = 15'd1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SENSITIVITY   = 2'd0,
        CFG_PADDLE_MODE   = 2'd1,
        CFG_INVERT_PADDLE = 2'd2,
        CFG_PADDLE_AXIS   = 2'd3
    } gcr_cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } gcr_state_t;

    // Which of the three scaled values is being computed
    typedef enum logic [1:0] {
        PH_PADDLE,
        PH_PEN_X,
        PH_PEN_Y
    } gcr_phase_t;

    // Divider command and status
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [SENS_W-1:0] den;
    } gcr_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gcr_div_status_t;

endpackage

@@ sv/gcr_div.sv @@
// ============================================================================
// Controller readout divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module gcr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gcr_pkg::gcr_div_cmd_t        cmd,
    output gcr_pkg::gcr_div_status_t     stat,
    output logic [gcr_pkg::NUM_W-1:0]    quotient
);
    import gcr_pkg::*;

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [SENS_W-1:0] rem_reg, rem_next;
    logic [SENS_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [SENS_W:0]   trial;
    logic [SENS_W:0]   diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit, try a subtract
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Next-state logic
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            num_next  = cmd.num;
            rem_next  = '0;
            den_next  = cmd.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[SENS_W-1:0] : trial[SENS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

@@ sv/game_controller_readout.sv @@
// ============================================================================
// Game controller readout
// Stick position and button state with direction mask, paddle and light-pen
// readouts scaled by the sensitivity register.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ----------------------------------
//  s_       in         s_valid / s_ready    opcode, pos_x_in, pos_y_in,
//                                           button_index, button_pressed
//  m_       out        m_valid / m_ready    stick_mask, trigger, paddle_value,
//                                           pen_x, pen_y
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each input transaction makes three passes through the shared 22-step
//  divider (multiply, 22 steps, store), then the output register is loaded.
//  s_ready is low while a transaction is in work; a waiting result does not
//  block acceptance, but a finished one waits for m_ready before loading
//  while an earlier result is still held.
//  Synchronous active-low reset; configuration is always ready.
//
module game_controller_readout (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [gcr_pkg::SENS_W-1:0]     cfg_data,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic signed [gcr_pkg::POS_W-1:0] s_pos_x_in,
    input  logic signed [gcr_pkg::POS_W-1:0] s_pos_y_in,
    input  logic [1:0]                     s_button_index,
    input  logic                           s_button_pressed,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_stick_mask,
    output logic                           m_trigger,
    output logic [7:0]                     m_paddle_value,
    output logic [7:0]                     m_pen_x,
    output logic [6:0]                     m_pen_y
);
    import gcr_pkg::*;

    // Configuration registers
    logic [SENS_W-1:0] sensitivity_reg;
    logic              paddle_mode_reg;
    logic              invert_paddle_reg;
    logic              paddle_axis_reg;

    // Controller state
    logic signed [POS_W-1:0] position_x_reg;
    logic signed [POS_W-1:0] position_y_reg;
    logic [1:0]              buttons_reg;

    // Sequencer
    gcr_state_t state_reg, state_next;
    gcr_phase_t phase_reg, phase_next;
    logic       op_neg_reg;
    logic       div_start;
    logic       store_res;
    logic       load_out;

    // Intermediate results
    logic [7:0] paddle_res_reg;
    logic [7:0] pen_x_res_reg;
    logic [6:0] pen_y_res_reg;

    // Output registers
    logic       m_valid_reg;
    logic [3:0] m_stick_mask_reg;
    logic       m_trigger_reg;
    logic [7:0] m_paddle_value_reg;
    logic [7:0] m_pen_x_reg;
    logic [6:0] m_pen_y_reg;

    // Divider interface
    gcr_div_cmd_t    div_cmd;
    gcr_div_status_t div_stat;
    logic [NUM_W-1:0] div_quotient;

    logic s_accept;
    logic cfg_accept;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Operand select and constant multiply for the current phase
    logic signed [OP_W-1:0] op;
    logic [CONST_W-1:0]     scale;
    logic                   op_neg;
    logic [OP_W-1:0]        op_mag;
    logic [OP_W+CONST_W-1:0] prod_full;

    always_comb begin
        op    = OP_W'(position_x_reg);
        scale = CONST_W'(PADDLE_CENTRE);
        case (phase_reg)
            PH_PADDLE: begin
                op = paddle_axis_reg ? OP_W'(position_y_reg) : OP_W'(position_x_reg);
                if (invert_paddle_reg) begin
                    op = -op;
                end
                scale = CONST_W'(PADDLE_CENTRE);
            end
            PH_PEN_X: begin
                op    = OP_W'(position_x_reg);
                scale = CONST_W'(PEN_X_HALF);
            end
            PH_PEN_Y: begin
                op    = OP_W'(position_y_reg);
                scale = CONST_W'(PEN_Y_HALF);
            end
            default: begin
                op    = OP_W'(position_x_reg);
                scale = CONST_W'(PADDLE_CENTRE);
            end
        endcase
    end

    assign op_neg    = op[OP_W-1];
    assign op_mag    = op_neg ? OP_W'(-op) : OP_W'(op);
    assign prod_full = op_mag * scale;

    assign div_cmd.start = div_start;
    assign div_cmd.num   = prod_full[NUM_W-1:0];
    assign div_cmd.den   = sensitivity_reg;

    gcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // Re-sign the quotient, add the centre and clamp
    logic signed [RES_W-1:0] q_signed;
    logic signed [RES_W-1:0] centre;
    logic signed [RES_W-1:0] lo;
    logic signed [RES_W-1:0] hi;
    logic signed [RES_W-1:0] sum;
    logic signed [RES_W-1:0] clamped;

    always_comb begin
        centre = RES_W'(PADDLE_CENTRE);
        lo     = RES_W'(PADDLE_MIN);
        hi     = RES_W'(PADDLE_MAX);
        case (phase_reg)
            PH_PADDLE: begin
                centre = RES_W'(PADDLE_CENTRE);
                lo     = RES_W'(PADDLE_MIN);
                hi     = RES_W'(PADDLE_MAX);
            end
            PH_PEN_X: begin
                centre = RES_W'(PEN_X_CENTRE);
                lo     = RES_W'(PEN_X_MIN);
                hi     = RES_W'(PEN_X_MAX);
            end
            PH_PEN_Y: begin
                centre = RES_W'(PEN_Y_CENTRE);
                lo     = RES_W'(PEN_Y_MIN);
                hi     = RES_W'(PEN_Y_MAX);
            end
            default: begin
                centre = RES_W'(PADDLE_CENTRE);
                lo     = RES_W'(PADDLE_MIN);
                hi     = RES_W'(PADDLE_MAX);
            end
        endcase
    end

    assign q_signed = signed'({{(RES_W-NUM_W){1'b0}}, div_quotient});
    assign sum      = op_neg_reg ? (centre - q_signed) : (centre + q_signed);
    assign clamped  = (sum < lo) ? lo : ((sum > hi) ? hi : sum);

    // Direction mask and trigger from the current state
    logic signed [OP_W-1:0] sens_pos;
    logic signed [OP_W-1:0] sens_neg;
    logic signed [OP_W-1:0] pos_x_ext;
    logic signed [OP_W-1:0] pos_y_ext;
    logic [3:0]             mask_act;
    logic                   trig;

    assign sens_pos  = signed'({2'b00, sensitivity_reg});
    assign sens_neg  = -sens_pos;
    assign pos_x_ext = OP_W'(position_x_reg);
    assign pos_y_ext = OP_W'(position_y_reg);

    always_comb begin
        if (paddle_mode_reg) begin
            mask_act = {2'b00, buttons_reg};
            trig     = buttons_reg[paddle_axis_reg];
        end else begin
            mask_act[0] = (pos_y_ext <= sens_neg);
            mask_act[1] = (pos_y_ext >= sens_pos);
            mask_act[2] = (pos_x_ext <= sens_neg);
            mask_act[3] = (pos_x_ext >= sens_pos);
            trig        = buttons_reg[0];
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        store_res  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MUL;
                    phase_next = PH_PADDLE;
                end
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    store_res = 1'b1;
                    case (phase_reg)
                        PH_PADDLE: begin
                            phase_next = PH_PEN_X;
                            state_next = ST_MUL;
                        end
                        PH_PEN_X: begin
                            phase_next = PH_PEN_Y;
                            state_next = ST_MUL;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and controller state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_PADDLE;
            m_valid_reg       <= 1'b0;
            sensitivity_reg   <= SENS_RESET;
            paddle_mode_reg   <= 1'b0;
            invert_paddle_reg <= 1'b0;
            paddle_axis_reg   <= 1'b0;
            position_x_reg    <= '0;
            position_y_reg    <= '0;
            buttons_reg       <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;

            // result handshake
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_accept) begin
                case (gcr_cfg_index_t'(cfg_index))
                    CFG_SENSITIVITY: begin
                        sensitivity_reg <= (cfg_data == '0) ? SENS_MIN : cfg_data;
                    end
                    CFG_PADDLE_MODE:   paddle_mode_reg   <= cfg_data[0];
                    CFG_INVERT_PADDLE: invert_paddle_reg <= cfg_data[0];
                    CFG_PADDLE_AXIS:   paddle_axis_reg   <= cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // controller state update on an input transaction
            if (s_accept) begin
                if (s_opcode == OP_SET_POS) begin
                    position_x_reg <= s_pos_x_in;
                    position_y_reg <= s_pos_y_in;
                end else if (!s_button_index[1]) begin
                    buttons_reg[s_button_index[0]] <= s_button_pressed;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (div_start) begin
            op_neg_reg <= op_neg;
        end
        if (store_res) begin
            case (phase_reg)
                PH_PADDLE: paddle_res_reg <= clamped[7:0];
                PH_PEN_X:  pen_x_res_reg  <= clamped[7:0];
                default:   pen_y_res_reg  <= clamped[6:0];
            endcase
        end
        if (load_out) begin
            m_stick_mask_reg   <= ~mask_act;
            m_trigger_reg      <= trig;
            m_paddle_value_reg <= paddle_res_reg;
            m_pen_x_reg        <= pen_x_res_reg;
            m_pen_y_reg        <= pen_y_res_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_stick_mask   = m_stick_mask_reg;
    assign m_trigger      = m_trigger_reg;
    assign m_paddle_value = m_paddle_value_reg;
    assign m_pen_x        = m_pen_x_reg;
    assign m_pen_y        = m_pen_y_reg;

    // Assertions
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_sens_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sensitivity_reg != '0)
        else $error("sensitivity register holds zero");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input ready right after a transaction was accepted");

    a_paddle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_paddle_value >= 8'd1) && (m_paddle_value <= 8'd227))
        else $error("paddle value out of range");

endmodule

@@ sim/readout_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Controller readout checker
// Watches the configuration, input and result channels of the controller
// readout block, predicts every result from its own copy of the stick state
// and registers, and compares each result transaction field by field.
// ============================================================================
module readout_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [gcr_pkg::SENS_W-1:0]       cfg_data,
    // input channel
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_opcode,
    input  logic signed [gcr_pkg::POS_W-1:0] s_pos_x_in,
    input  logic signed [gcr_pkg::POS_W-1:0] s_pos_y_in,
    input  logic [1:0]                       s_button_index,
    input  logic                             s_button_pressed,
    // result channel
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [3:0]                       m_stick_mask,
    input  logic                             m_trigger,
    input  logic [7:0]                       m_paddle_value,
    input  logic [7:0]                       m_pen_x,
    input  logic [6:0]                       m_pen_y,
    // end of run: flag any readout still owed
    input  logic                             end_check,
    output int                               fail_count,
    output int                               results_seen
);

    import gcr_pkg::*;

    localparam int PEN_X_SPAN = 194;
    localparam int PEN_Y_SPAN = 124;
    localparam int MAX_LINES  = 50;

    typedef struct packed {
        logic [3:0] stick_mask;
        logic       trigger;
        logic [7:0] paddle_value;
        logic [7:0] pen_x;
        logic [6:0] pen_y;
    } readout_t;

    // Shadow of the block's registers and stick state
    logic [SENS_W-1:0]        sens_reg;
    logic                     paddle_mode_reg;
    logic                     invert_reg;
    logic                     axis_reg;
    logic signed [POS_W-1:0]  stick_x;
    logic signed [POS_W-1:0]  stick_y;
    logic [1:0]               button_state;

    readout_t expected_readouts[$];
    logic     leftover_checked;

    initial begin
        fail_count       = 0;
        results_seen     = 0;
        leftover_checked = 1'b0;
    end

    task automatic report_failure(input string msg);
        if (fail_count < MAX_LINES)
            $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Apply one input transaction to the stick state and work out its readout
    function automatic readout_t predict_readout(
        input logic                    op,
        input logic signed [POS_W-1:0] x_in,
        input logic signed [POS_W-1:0] y_in,
        input logic [1:0]              idx,
        input logic                    pressed
    );
        readout_t   r;
        longint     s;
        longint     p;
        longint     v;
        logic [3:0] dir;

        if (op == OP_SET_POS) begin
            stick_x = x_in;
            stick_y = y_in;
        end else if (idx <= 2'd1) begin
            button_state[idx[0]] = pressed;
        end

        s   = longint'(sens_reg);
        dir = 4'b0000;
        if (paddle_mode_reg) begin
            dir       = {2'b00, button_state};
            r.trigger = button_state[axis_reg];
        end else begin
            if (longint'(stick_y) <= -s) dir[0] = 1'b1;
            if (longint'(stick_y) >=  s) dir[1] = 1'b1;
            if (longint'(stick_x) <= -s) dir[2] = 1'b1;
            if (longint'(stick_x) >=  s) dir[3] = 1'b1;
            r.trigger = button_state[0];
        end
        r.stick_mask = ~dir;

        // Paddle pot: chosen axis, optional negation (-32768 becomes +32768)
        p = axis_reg ? longint'(stick_y) : longint'(stick_x);
        if (invert_reg) p = -p;
        v = clamp_range(PADDLE_CENTRE + (p * PADDLE_CENTRE) / s, PADDLE_MIN, PADDLE_MAX);
        r.paddle_value = v[7:0];

        // Light pen, truncating division over twice the sensitivity
        v = clamp_range(PEN_X_CENTRE + (longint'(stick_x) * PEN_X_SPAN) / (s * 2),
                        PEN_X_MIN, PEN_X_MAX);
        r.pen_x = v[7:0];
        v = clamp_range(PEN_Y_CENTRE + (longint'(stick_y) * PEN_Y_SPAN) / (s * 2),
                        PEN_Y_MIN, PEN_Y_MAX);
        r.pen_y = v[6:0];
        return r;
    endfunction

    // Channel monitor: results first, then inputs, then register writes
    always @(posedge aclk) begin
        readout_t want;
        readout_t got;

        if (!aresetn) begin
            sens_reg        = SENS_RESET;
            paddle_mode_reg = 1'b0;
            invert_reg      = 1'b0;
            axis_reg        = 1'b0;
            stick_x         = '0;
            stick_y         = '0;
            button_state    = 2'b00;
            expected_readouts.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                got = '{m_stick_mask, m_trigger, m_paddle_value, m_pen_x, m_pen_y};
                if (expected_readouts.size() == 0) begin
                    report_failure($sformatf("readout %0d arrived with none expected",
                                             results_seen));
                end else begin
                    want = expected_readouts.pop_front();
                    if (got.stick_mask !== want.stick_mask)
                        report_failure($sformatf("readout %0d stick_mask %h, expected %h",
                                       results_seen, got.stick_mask, want.stick_mask));
                    if (got.trigger !== want.trigger)
                        report_failure($sformatf("readout %0d trigger %b, expected %b",
                                       results_seen, got.trigger, want.trigger));
                    if (got.paddle_value !== want.paddle_value)
                        report_failure($sformatf("readout %0d paddle_value %0d, expected %0d",
                                       results_seen, got.paddle_value, want.paddle_value));
                    if (got.pen_x !== want.pen_x)
                        report_failure($sformatf("readout %0d pen_x %0d, expected %0d",
                                       results_seen, got.pen_x, want.pen_x));
                    if (got.pen_y !== want.pen_y)
                        report_failure($sformatf("readout %0d pen_y %0d, expected %0d",
                                       results_seen, got.pen_y, want.pen_y));
                end
            end

            if (s_valid && s_ready)
                expected_readouts.push_back(predict_readout(s_opcode, s_pos_x_in, s_pos_y_in,
                                                            s_button_index, s_button_pressed));

            if (cfg_valid && cfg_ready) begin
                case (gcr_cfg_index_t'(cfg_index))
                    CFG_SENSITIVITY: begin
                        sens_reg = (cfg_data == '0) ? SENS_MIN : cfg_data;
                    end
                    CFG_PADDLE_MODE:   paddle_mode_reg = cfg_data[0];
                    CFG_INVERT_PADDLE: invert_reg      = cfg_data[0];
                    CFG_PADDLE_AXIS:   axis_reg        = cfg_data[0];
                    default: ;
                endcase
            end
        end

        // Anything still queued at the end was never delivered
        if (end_check && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_readouts.size() != 0)
                report_failure($sformatf("%0d readouts never delivered",
                                         expected_readouts.size()));
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Controller readout testbench
// Drives register settings and stick/button transactions into the readout
// block under several idle and stall mixes, including a long result hold-off;
// the checker instance predicts and compares every readout.
// ============================================================================
module testbench;

    import gcr_pkg::*;

    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int NUM_SETTINGS    = 10;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 100;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     cfg_valid        = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index        = '0;
    logic [SENS_W-1:0]        cfg_data         = '0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic                     s_opcode         = 1'b0;
    logic signed [POS_W-1:0]  s_pos_x_in       = '0;
    logic signed [POS_W-1:0]  s_pos_y_in       = '0;
    logic [1:0]               s_button_index   = '0;
    logic                     s_button_pressed = 1'b0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic [3:0]               m_stick_mask;
    logic                     m_trigger;
    logic [7:0]               m_paddle_value;
    logic [7:0]               m_pen_x;
    logic [6:0]               m_pen_y;
    logic                     end_check        = 1'b0;

    int fail_count;
    int results_seen;
    int items_sent     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cur_sens       = 8192;

    game_controller_readout i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_pos_x_in       (s_pos_x_in),
        .s_pos_y_in       (s_pos_y_in),
        .s_button_index   (s_button_index),
        .s_button_pressed (s_button_pressed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_stick_mask     (m_stick_mask),
        .m_trigger        (m_trigger),
        .m_paddle_value   (m_paddle_value),
        .m_pen_x          (m_pen_x),
        .m_pen_y          (m_pen_y)
    );

    readout_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_pos_x_in       (s_pos_x_in),
        .s_pos_y_in       (s_pos_y_in),
        .s_button_index   (s_button_index),
        .s_button_pressed (s_button_pressed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_stick_mask     (m_stick_mask),
        .m_trigger        (m_trigger),
        .m_paddle_value   (m_paddle_value),
        .m_pen_x          (m_pen_x),
        .m_pen_y          (m_pen_y),
        .end_check        (end_check),
        .fail_count       (fail_count),
        .results_seen     (results_seen)
    );

    // Clock
    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL game_controller_readout");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Register write; valid stays high for a following write
    task automatic write_reg(input gcr_cfg_index_t idx, input logic [SENS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Full register setting; only called with the block idle
    task automatic apply_config(input logic [SENS_W-1:0] sens, input logic mode,
                                input logic inv, input logic axis);
        write_reg(CFG_SENSITIVITY, sens);
        write_reg(CFG_PADDLE_MODE, {14'd0, mode});
        write_reg(CFG_INVERT_PADDLE, {14'd0, inv});
        write_reg(CFG_PADDLE_AXIS, {14'd0, axis});
        cfg_valid <= 1'b0;
        cur_sens = (sens == '0) ? 1 : int'(sens);
        settings_used++;
    endtask

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y, input logic [1:0] idx,
                             input logic pressed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_pos_x_in       <= x;
        s_pos_y_in       <= y;
        s_button_index   <= idx;
        s_button_pressed <= pressed;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_pos(input int x, input int y);
        send_item(OP_SET_POS, x[POS_W-1:0], y[POS_W-1:0], 2'($urandom_range(3)),
                  1'($urandom_range(1)));
    endtask

    task automatic send_button(input logic [1:0] idx, input logic pressed);
        send_item(OP_SET_BUTTON, POS_W'($urandom), POS_W'($urandom), idx, pressed);
    endtask

    // Stop offering and wait until every readout has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen != items_sent) @(posedge aclk);
    endtask

    // Coordinates biased toward the thresholds and the range ends
    function automatic int pick_coord(input int sens);
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return sens;
            3: return -sens;
            4: return sens + ($urandom_range(1) ? 1 : -1);
            5: return -sens + ($urandom_range(1) ? 1 : -1);
            6: return int'($urandom_range(511)) - 256;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic send_random();
        if ($urandom_range(1))
            send_pos(pick_coord(cur_sens), pick_coord(cur_sens));
        else if ($urandom_range(9) < 8)
            send_button(2'($urandom_range(1)), 1'($urandom_range(1)));
        else
            send_button(2'($urandom_range(3, 2)), 1'($urandom_range(1)));
    endtask

    // Stimulus and verdict
    initial begin
        logic [SENS_W-1:0] sens;
        logic              mode;
        logic              inv;
        logic              axis;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset setting, range ends, exact thresholds, ignored buttons
        send_pos(0, 0);
        send_pos(32767, 32767);
        send_pos(-32768, -32768);
        send_pos(8192, -8192);
        send_pos(-8192, 8192);
        send_pos(8191, -8191);
        send_button(2'd0, 1'b1);
        send_button(2'd1, 1'b1);
        send_button(2'd2, 1'b0);
        send_button(2'd3, 1'b0);
        send_button(2'd0, 1'b0);
        wait_drained();

        // Sensitivity written as zero, paddle mode, inverted most-negative x
        apply_config(15'd0, 1'b1, 1'b1, 1'b0);
        send_pos(-32768, 32767);
        send_button(2'd1, 1'b1);
        send_button(2'd0, 1'b1);
        send_pos(1, -1);
        wait_drained();

        apply_config(15'd32767, 1'b1, 1'b0, 1'b1);
        send_pos(32767, -32768);
        send_button(2'd1, 1'b0);
        send_pos(-32767, 32767);
        wait_drained();

        apply_config(15'd1, 1'b0, 1'b1, 1'b1);
        send_pos(-32768, -32768);
        send_pos(-1, 1);
        send_pos(0, 0);
        send_button(2'd3, 1'b1);
        wait_drained();

        // Random: each setting runs through every idle/stall mix
        for (int k = 0; k < NUM_SETTINGS; k++) begin
            case (k)
                0: sens = 15'd0;
                1: sens = 15'd1;
                2: sens = 15'd32767;
                3: sens = 15'd8192;
                4: sens = 15'd2;
                5: sens = 15'($urandom_range(300, 1));
                6: sens = 15'($urandom_range(32767, 1));
                7: sens = 15'd16384;
                8: sens = 15'($urandom_range(32767));
                default: sens = 15'd114;
            endcase
            if (k < 8) begin
                mode = k[0];
                inv  = k[1];
                axis = k[2];
            end else begin
                mode = 1'($urandom_range(1));
                inv  = 1'($urandom_range(1));
                axis = 1'($urandom_range(1));
            end
            apply_config(sens, mode, inv, axis);

            for (int ph = 0; ph < 4; ph++) begin
                case (ph)
                    0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                    1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
                    2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
                    default: begin src_idle_pct = 9; sink_stall_pct = 9; end
                endcase
                // One long result hold-off while the sender keeps offering
                if (k == 3 && ph == 0) hold_requests++;
                for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
            end
            wait_drained();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("Run covered %0d input transactions and %0d readouts over %0d register settings,",
                 items_sent, results_seen, settings_used);
        $display("with four idle/stall mixes per setting and one %0d-cycle readout hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS game_controller_readout");
        end else begin
            $display("FAIL game_controller_readout");
        end
        $finish;
    end

endmodule
